FILE: rtl/core/ecc_pkg.sv
// ecc_pkg: shared constants, arctangent table and saturating add/subtract
// for the ellipse to conic coefficient pipeline. No dependencies.
package ecc_pkg;

  // pipeline depths of the sub-units
  localparam int LAT_MUL      = 5;
  localparam int LAT_RECIP    = 63;
  localparam int LAT_CORDIC   = 28;
  localparam int LAT_TOTAL    = LAT_RECIP + 3 * LAT_MUL + 3;
  localparam int CORDIC_STEPS = 24;
  localparam int QUO_W        = 59;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sh026DD3B6A;
  localparam logic [34:0]        RAD_PER_UNIT = 35'd19190098069;
  localparam logic signed [63:0] ONE_Q40      = 64'sd1099511627776;
  localparam logic signed [63:0] S64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN      = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic              ovf;
    logic signed [63:0] val;
  } sat_t;

  // arctangent of 2^-i in Q30, truncated
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // saturating 64-bit add
  function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  // saturating 64-bit subtract
  function automatic sat_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} - {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/ecc_delay.sv
// ecc_delay: fixed-length register line used to align operands between
// pipeline phases. No dependencies.
module ecc_delay #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  // shift the line along every cycle
  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int k = 1; k < N; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign q = line[N-1];

endmodule

FILE: rtl/core/ecc_mrs.sv
// ecc_mrs: pipelined signed 64x64 multiply, round half away from zero by
// 2^SH and saturate to 64 bits. Depends on ecc_pkg.
module ecc_mrs import ecc_pkg::*; #(
  parameter int SH = 30
) (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               ovf
);

  logic        neg1, neg2, neg3, neg4;
  logic [63:0] ua, ub;
  logic [63:0] p00, p01, p10, p11;
  logic [127:0] prod;
  logic [127:0] rnd;
  logic [63:0] m_raw, lim, m4;
  logic        sat, ovf4;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    neg1 <= a[63] ^ b[63];
    ua   <= a[63] ? 64'(-a) : 64'(a);
    ub   <= b[63] ? 64'(-b) : 64'(b);
  end

  // four 32x32 partial products
  always_ff @(posedge clk) begin
    neg2 <= neg1;
    p00  <= {32'b0, ua[31:0]} * {32'b0, ub[31:0]};
    p01  <= {32'b0, ua[31:0]} * {32'b0, ub[63:32]};
    p10  <= {32'b0, ua[63:32]} * {32'b0, ub[31:0]};
    p11  <= {32'b0, ua[63:32]} * {32'b0, ub[63:32]};
  end

  // full product
  always_ff @(posedge clk) begin
    neg3 <= neg2;
    prod <= {64'b0, p00} + ({64'b0, p01} << 32) + ({64'b0, p10} << 32) + {p11, 64'b0};
  end

  // rounding, scaling and range check
  always_comb begin
    rnd   = prod + (128'd1 << (SH - 1));
    m_raw = rnd[SH+63:SH];
    lim   = neg3 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat   = (|rnd[127:SH+64]) || (m_raw > lim);
  end

  always_ff @(posedge clk) begin
    neg4 <= neg3;
    m4   <= sat ? lim : m_raw;
    ovf4 <= sat;
  end

  // apply sign
  always_ff @(posedge clk) begin
    p   <= neg4 ? $signed(-m4) : $signed(m4);
    ovf <= ovf4;
  end

endmodule

FILE: rtl/core/ecc_recip.sv
// ecc_recip: pipelined signed reciprocal square R = sign(w)*round(2^58/w^2)
// of a full axis, one quotient bit per stage. Depends on ecc_pkg.
module ecc_recip import ecc_pkg::*; (
  input  logic               clk,
  input  logic signed [23:0] w,
  output logic signed [63:0] r
);

  logic        neg1, zero1, neg2, zero2;
  logic [23:0] mag1;
  logic [47:0] w2;

  logic [46:0]      den [QUO_W+1];
  logic [46:0]      rem [QUO_W+1];
  logic [QUO_W-1:0] num [QUO_W+1];
  logic [QUO_W-1:0] quo [QUO_W+1];
  logic             sg  [QUO_W+1];
  logic             zr  [QUO_W+1];

  logic signed [63:0] qx;

  // sign and magnitude
  always_ff @(posedge clk) begin
    neg1  <= w[23];
    zero1 <= (w == 24'sd0);
    mag1  <= w[23] ? 24'(-w) : 24'(w);
  end

  // square of the axis
  always_ff @(posedge clk) begin
    neg2  <= neg1;
    zero2 <= zero1;
    w2    <= {24'b0, mag1} * {24'b0, mag1};
  end

  // dividend 2^58 + w^2/2, divisor w^2
  always_ff @(posedge clk) begin
    den[0] <= w2[46:0];
    num[0] <= {1'b1, 12'b0, w2[46:1]};
    rem[0] <= '0;
    quo[0] <= '0;
    sg[0]  <= neg2;
    zr[0]  <= zero2;
  end

  // restoring division, one bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [47:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[k], num[k][QUO_W-1]};
      ge    = trial >= {1'b0, den[k]};
    end
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? 47'(trial - {1'b0, den[k]}) : trial[46:0];
      quo[k+1] <= {quo[k][QUO_W-2:0], ge};
      num[k+1] <= num[k] << 1;
      den[k+1] <= den[k];
      sg[k+1]  <= sg[k];
      zr[k+1]  <= zr[k];
    end
  end

  // sign, zero axis gives zero
  assign qx = $signed({5'b0, quo[QUO_W]});

  always_ff @(posedge clk) begin
    r <= zr[QUO_W] ? 64'sd0 : (sg[QUO_W] ? -qx : qx);
  end

endmodule

FILE: rtl/core/ecc_cordic.sv
// ecc_cordic: angle reduction, degree to radian scaling and a 24-stage
// rotation pipeline giving cosine and sine in Q30. Depends on ecc_pkg.
module ecc_cordic import ecc_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);

  logic signed [16:0] neg_ang, r1, r2, a_full;
  logic               flip_a;
  logic signed [13:0] a_q;
  logic               flip_q, flip_b, neg_b;
  logic [12:0]        mag;
  logic [47:0]        prod_b, rsum;

  logic signed [33:0] xs [CORDIC_STEPS+1];
  logic signed [33:0] ys [CORDIC_STEPS+1];
  logic signed [33:0] zs [CORDIC_STEPS+1];
  logic               fl [CORDIC_STEPS+1];

  // negate and reduce to a quarter turn either side of zero
  always_comb begin
    neg_ang = -{angle[15], angle};
    if (neg_ang >= 17'sd23040) begin
      r1 = neg_ang - 17'sd23040;
    end else if (neg_ang <= -17'sd23040) begin
      r1 = neg_ang + 17'sd23040;
    end else begin
      r1 = neg_ang;
    end
    r2 = (r1 < 17'sd0) ? r1 + 17'sd23040 : r1;
    if (r2 > 17'sd17280) begin
      a_full = r2 - 17'sd23040;
      flip_a = 1'b0;
    end else if (r2 > 17'sd5760) begin
      a_full = r2 - 17'sd11520;
      flip_a = 1'b1;
    end else begin
      a_full = r2;
      flip_a = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    a_q    <= 14'(a_full);
    flip_q <= flip_a;
  end

  // scale to radians
  assign mag = a_q[13] ? 13'(-a_q) : 13'(a_q);

  always_ff @(posedge clk) begin
    prod_b <= {35'b0, mag} * {13'b0, RAD_PER_UNIT};
    neg_b  <= a_q[13];
    flip_b <= flip_q;
  end

  // round to Q30 and seed the rotation
  assign rsum = prod_b + 48'd32768;

  always_ff @(posedge clk) begin
    xs[0] <= CORDIC_GAIN;
    ys[0] <= '0;
    zs[0] <= neg_b ? -$signed(34'(rsum[47:16])) : $signed(34'(rsum[47:16]));
    fl[0] <= flip_b;
  end

  // rotation stages
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (zs[k] >= 34'sd0) begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - atan_q30(5'(k));
      end else begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + atan_q30(5'(k));
      end
      fl[k+1] <= fl[k];
    end
  end

  // half-turn correction
  always_ff @(posedge clk) begin
    cos_q <= fl[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
    sin_q <= fl[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
  end

endmodule

FILE: rtl/core/ellipse_to_conic_coefficients.sv
// ellipse_to_conic_coefficients: rotated ellipse to six conic coefficients.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// Depth is set by the 59-stage reciprocal divider plus three multiplier phases.
// Reset clears only the valid line; data registers are not reset.
// Depends on ecc_pkg, ecc_delay, ecc_mrs, ecc_recip and ecc_cordic.
module ellipse_to_conic_coefficients import ecc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] center_x,
  input  logic signed [23:0] center_y,
  input  logic signed [23:0] full_width,
  input  logic signed [23:0] full_height,
  input  logic signed [15:0] angle_deg,
  output logic               done,
  output logic signed [63:0] const_coef,
  output logic signed [63:0] x_coef,
  output logic signed [63:0] y_coef,
  output logic signed [63:0] xx_coef,
  output logic signed [63:0] yy_coef,
  output logic signed [63:0] xy_coef,
  output logic               overflow
);

  // round half away from zero by 2^8
  function automatic logic signed [63:0] rnd8(input logic signed [58:0] v);
    logic [58:0] m;
    logic [58:0] r;
    m = v[58] ? 59'(-v) : 59'(v);
    r = (m + 59'd128) >> 8;
    return v[58] ? -$signed(64'(r)) : $signed(64'(r));
  endfunction

  logic signed [23:0] cx0, cy0, w0, h0;
  logic signed [15:0] ang0;
  logic               v0;
  logic [LAT_TOTAL-1:0] vpipe;

  logic signed [33:0] cos_c, sin_c, c1, s1;
  logic signed [63:0] rx1, ry1, rx2, ry2, rd1, rd2;
  logic signed [23:0] cx1, cy1, cx4, cy4;

  logic signed [57:0] pxs, pyc, pxc, pys;
  logic signed [58:0] su, sv;
  logic signed [63:0] u3, v3, u2, v2, u_t3, v_t3;

  logic signed [63:0] c2, s2, sc2;
  logic               f_c2, f_s2, f_sc2, ovf_a, ovf_a3, ovf_b;
  logic signed [63:0] m1, m2, m3, m4, m5, m6, m7;
  logic               fm1, fm2, fm3, fm4, fm5, fm6, fm7;

  sat_t r_axx, r_ayy, r_naxy;
  logic signed [63:0] axx3, ayy3, axy3, naxy3;
  logic               ovf_c, ovf_c4, ovf_d;

  logic signed [63:0] t1, t2;
  logic               ft1, ft2;
  logic [64:0]        t1d, t2d;
  logic signed [63:0] n1, n2, n3, n4;
  logic               fn1, fn2, fn3, fn4;
  logic [191:0]       quad4;

  sat_t r_ax, r_ay, r_s12, r_ao;
  logic signed [63:0] ax5, ay5, s12_5, axx5, ayy5, axy5;
  logic               ovf_e;

  assign busy = 1'b0;

  // request register
  always_ff @(posedge clk) begin
    cx0  <= center_x;
    cy0  <= center_y;
    w0   <= full_width;
    h0   <= full_height;
    ang0 <= angle_deg;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      vpipe <= '0;
    end else begin
      v0    <= start & ~busy;
      vpipe <= {vpipe[LAT_TOTAL-2:0], v0};
    end
  end

  assign done = vpipe[LAT_TOTAL-1];

  // sine/cosine and reciprocal squares in parallel
  ecc_cordic u_cordic (.clk(clk), .angle(ang0), .cos_q(cos_c), .sin_q(sin_c));
  ecc_recip  u_recip_x (.clk(clk), .w(w0), .r(rx1));
  ecc_recip  u_recip_y (.clk(clk), .w(h0), .r(ry1));

  ecc_delay #(.W(68), .N(LAT_RECIP - LAT_CORDIC)) u_dly_cs (
    .clk(clk), .d({cos_c, sin_c}), .q({c1, s1}));
  ecc_delay #(.W(48), .N(LAT_RECIP)) u_dly_c1 (
    .clk(clk), .d({cx0, cy0}), .q({cx1, cy1}));

  // phase 1: squares of sine and cosine and twice their product
  ecc_mrs #(.SH(30)) u_c2  (.clk(clk), .a(64'(c1)), .b(64'(c1)), .p(c2),  .ovf(f_c2));
  ecc_mrs #(.SH(30)) u_s2  (.clk(clk), .a(64'(s1)), .b(64'(s1)), .p(s2),  .ovf(f_s2));
  ecc_mrs #(.SH(29)) u_sc2 (.clk(clk), .a(64'(s1)), .b(64'(c1)), .p(sc2), .ovf(f_sc2));

  // rotated center terms u and v
  always_ff @(posedge clk) begin
    pxs <= 58'(cx1) * 58'(s1);
    pyc <= 58'(cy1) * 58'(c1);
    pxc <= 58'(cx1) * 58'(c1);
    pys <= 58'(cy1) * 58'(s1);
    su  <= 59'(pxs) + 59'(pyc);
    sv  <= 59'(pxc) - 59'(pys);
    u3  <= rnd8(su);
    v3  <= rnd8(sv);
  end

  ecc_delay #(.W(128), .N(LAT_MUL - 3)) u_dly_uv (
    .clk(clk), .d({u3, v3}), .q({u2, v2}));

  // axis difference and reciprocal alignment
  always_ff @(posedge clk) begin
    rd1 <= ry1 - rx1;
  end

  ecc_delay #(.W(64), .N(LAT_MUL - 1)) u_dly_rd (.clk(clk), .d(rd1), .q(rd2));
  ecc_delay #(.W(128), .N(LAT_MUL)) u_dly_r (
    .clk(clk), .d({rx1, ry1}), .q({rx2, ry2}));

  assign ovf_a = f_c2 | f_s2 | f_sc2;

  // phase 2: weight the reciprocals
  ecc_mrs #(.SH(30)) u_m1 (.clk(clk), .a(c2),  .b(rx2), .p(m1), .ovf(fm1));
  ecc_mrs #(.SH(30)) u_m2 (.clk(clk), .a(s2),  .b(ry2), .p(m2), .ovf(fm2));
  ecc_mrs #(.SH(30)) u_m3 (.clk(clk), .a(s2),  .b(rx2), .p(m3), .ovf(fm3));
  ecc_mrs #(.SH(30)) u_m4 (.clk(clk), .a(c2),  .b(ry2), .p(m4), .ovf(fm4));
  ecc_mrs #(.SH(30)) u_m5 (.clk(clk), .a(sc2), .b(rd2), .p(m5), .ovf(fm5));
  ecc_mrs #(.SH(30)) u_m6 (.clk(clk), .a(ry2), .b(u2),  .p(m6), .ovf(fm6));
  ecc_mrs #(.SH(30)) u_m7 (.clk(clk), .a(rx2), .b(v2),  .p(m7), .ovf(fm7));

  ecc_delay #(.W(128), .N(LAT_MUL)) u_dly_uv3 (
    .clk(clk), .d({u2, v2}), .q({u_t3, v_t3}));
  ecc_delay #(.W(1), .N(LAT_MUL)) u_dly_oa (.clk(clk), .d(ovf_a), .q(ovf_a3));

  assign ovf_b = ovf_a3 | fm1 | fm2 | fm3 | fm4 | fm5 | fm6 | fm7;

  // phase 3: quadratic terms
  always_comb begin
    r_axx  = sat_add(m1, m2);
    r_ayy  = sat_add(m3, m4);
    r_naxy = sat_sub(64'sd0, m5);
  end

  always_ff @(posedge clk) begin
    axx3  <= r_axx.val;
    ayy3  <= r_ayy.val;
    axy3  <= m5;
    naxy3 <= r_naxy.val;
    ovf_c <= ovf_b | r_axx.ovf | r_ayy.ovf | r_naxy.ovf;
  end

  // second factor of the constant term
  ecc_mrs #(.SH(30)) u_t1 (.clk(clk), .a(m6), .b(u_t3), .p(t1), .ovf(ft1));
  ecc_mrs #(.SH(30)) u_t2 (.clk(clk), .a(m7), .b(v_t3), .p(t2), .ovf(ft2));

  ecc_delay #(.W(65), .N(1)) u_dly_t1 (.clk(clk), .d({ft1, t1}), .q(t1d));
  ecc_delay #(.W(65), .N(1)) u_dly_t2 (.clk(clk), .d({ft2, t2}), .q(t2d));

  // phase 4: linear terms
  ecc_delay #(.W(48), .N(2 * LAT_MUL + 1)) u_dly_c4 (
    .clk(clk), .d({cx1, cy1}), .q({cx4, cy4}));

  ecc_mrs #(.SH(8)) u_n1 (.clk(clk), .a(naxy3), .b(64'(cy4)), .p(n1), .ovf(fn1));
  ecc_mrs #(.SH(7)) u_n2 (.clk(clk), .a(axx3),  .b(64'(cx4)), .p(n2), .ovf(fn2));
  ecc_mrs #(.SH(8)) u_n3 (.clk(clk), .a(naxy3), .b(64'(cx4)), .p(n3), .ovf(fn3));
  ecc_mrs #(.SH(7)) u_n4 (.clk(clk), .a(ayy3),  .b(64'(cy4)), .p(n4), .ovf(fn4));

  ecc_delay #(.W(192), .N(LAT_MUL)) u_dly_q (
    .clk(clk), .d({axx3, ayy3, axy3}), .q(quad4));
  ecc_delay #(.W(1), .N(LAT_MUL)) u_dly_oc (.clk(clk), .d(ovf_c), .q(ovf_c4));

  assign ovf_d = ovf_c4 | fn1 | fn2 | fn3 | fn4 | t1d[64] | t2d[64];

  // phase 5: linear differences and quadratic sum of the constant term
  always_comb begin
    r_ax  = sat_sub(n1, n2);
    r_ay  = sat_sub(n3, n4);
    r_s12 = sat_add($signed(t1d[63:0]), $signed(t2d[63:0]));
  end

  always_ff @(posedge clk) begin
    ax5   <= r_ax.val;
    ay5   <= r_ay.val;
    s12_5 <= r_s12.val;
    axx5  <= $signed(quad4[191:128]);
    ayy5  <= $signed(quad4[127:64]);
    axy5  <= $signed(quad4[63:0]);
    ovf_e <= ovf_d | r_ax.ovf | r_ay.ovf | r_s12.ovf;
  end

  // phase 6: constant term and result register
  assign r_ao = sat_sub(s12_5, ONE_Q40);

  always_ff @(posedge clk) begin
    const_coef <= r_ao.val;
    x_coef     <= ax5;
    y_coef     <= ay5;
    xx_coef    <= axx5;
    yy_coef    <= ayy5;
    xy_coef    <= axy5;
    overflow   <= ovf_e | r_ao.ovf;
  end

endmodule
